// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_n is high.
`define SGM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checked on every edge, reset included.
`define SGM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/sgmpca_pkg.sv =====
// ----------------------------------------------------------------------------
// sgmpca_pkg
// Shared types and constants of the SGM path cost aggregation block.
// ----------------------------------------------------------------------------
package sgmpca_pkg;

  localparam int COST_W     = 16;
  localparam int COLOR_W    = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DCOUNT_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_P1     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_P2     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DCOUNT = 2'd2;

  localparam logic [COST_W-1:0]   P1_RESET     = 16'd160;
  localparam logic [COST_W-1:0]   P2_RESET     = 16'd1600;
  localparam logic [DCOUNT_W-1:0] DCOUNT_RESET = 8'd64;

  // adaptive penalty divider: 30*p2 / (10*sum + 3)
  localparam int CSUM_W    = 10;
  localparam int NUM_W     = 21;
  localparam int DEN_W     = 13;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DINIT,
    ST_DIV,
    ST_P2A,
    ST_MIN,
    ST_SUM,
    ST_OUT
  } sgm_state_t;

endpackage

// ===== rtl/sgm_path_cost_aggregation.sv =====
// ----------------------------------------------------------------------------
// sgm_path_cost_aggregation
// Semi-global matching path cost aggregation along one scan path.
// ----------------------------------------------------------------------------
// One input word is one disparity of one pixel, disparity 0 first. A word
// passes accept with memory read, minimum search, difference add, then
// saturate and write back into the output register, in that order. The next
// word is accepted only after that write-back, so the block takes no new word
// while one is in flight; a result word held by out_tready low holds back the
// write-back of the next word for as long as it waits. Disparity 0 of a
// pixel that does not open a path first gets the color-adaptive P2 from a
// bit-serial divider of 21 iterations plus setup and clamp. Path costs of
// the current and previous pixel live in one two-bank memory of
// 2 * 2^ceil(log2(MAX_DISPARITIES)) entries with one write
// and two read ports; entries are undefined until written and there is no
// clearing pass.
module sgm_path_cost_aggregation #(
  parameter int MAX_DISPARITIES = 128,
  parameter int COST_BITS       = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sgmpca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgmpca_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // match_cost[15:0], red[23:16], green[31:24], blue[39:32]
  input  logic [sgmpca_pkg::IN_DATA_W-1:0]    in_tdata,
  // path_start
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // path_cost[15:0], sum_increment[31:16]
  output logic [sgmpca_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                out_tlast
);

  localparam int IDX_W = (MAX_DISPARITIES > 1) ? $clog2(MAX_DISPARITIES) : 1;
  localparam int CNT_W = $clog2(MAX_DISPARITIES + 1);
  localparam int CMP_W = (CNT_W > sgmpca_pkg::DCOUNT_W) ? CNT_W : sgmpca_pkg::DCOUNT_W;
  localparam int CW    = COST_BITS;
  localparam int SW0   = ((COST_BITS > sgmpca_pkg::COST_W) ? COST_BITS
                                                           : sgmpca_pkg::COST_W) + 1;
  localparam int SW    = SW0;
  localparam int TW    = SW + 1;
  localparam int MEM_D = 2 * (1 << IDX_W);

  localparam logic [CMP_W-1:0] CNT_MIN    = CMP_W'(2);
  localparam logic [CMP_W-1:0] CNT_MAX    = CMP_W'(MAX_DISPARITIES);
  localparam logic [TW-1:0]    COST_MAX_T = (TW'(1) << CW) - TW'(1);
  localparam logic [CW-1:0]    COST_MAX   = {CW{1'b1}};

  sgmpca_pkg::sgm_state_t state_r, state_nxt;

  // configuration
  logic [15:0] p1_r, p2_r;
  logic [7:0]  dcount_r;

  // path state
  logic             bank_r;
  logic [CW-1:0]    pmin_r, rmin_r;
  logic [IDX_W-1:0] didx_r;
  logic [23:0]      color_r;
  logic [15:0]      ap2_r;
  logic             first_r;

  // per-word registers
  logic [IDX_W-1:0] d_r;
  logic             last_r;
  logic [15:0]      c_r;
  logic [CW-1:0]    win_mid_r, win_hi_r;
  logic [SW-1:0]    best_r;
  logic [TW-1:0]    total_r;

  // divider
  logic [sgmpca_pkg::CSUM_W-1:0]    csum_r;
  logic [sgmpca_pkg::DEN_W-1:0]     den_r, rem_r;
  logic [sgmpca_pkg::NUM_W-1:0]     num_r;
  logic [sgmpca_pkg::DIV_CNT_W-1:0] dcnt_r;

  // memory
  logic [CW-1:0] mem [MEM_D];
  logic [CW-1:0] rd_a_r, rd_b_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_last_r;

  // control
  logic accept, commit, rd_en;

  // input fields
  logic [15:0] in_cost;
  logic [7:0]  in_red, in_green, in_blue;
  assign in_cost  = in_tdata[15:0];
  assign in_red   = in_tdata[23:16];
  assign in_green = in_tdata[31:24];
  assign in_blue  = in_tdata[39:32];

  // disparity count and end of pixel
  logic [CMP_W-1:0] dcount_x, cnt_eff, d_plus;
  logic             last_c, d_zero, first_eff;
  assign dcount_x  = CMP_W'(dcount_r);
  assign cnt_eff   = (dcount_x < CNT_MIN) ? CNT_MIN :
                     ((dcount_x > CNT_MAX) ? CNT_MAX : dcount_x);
  assign d_plus    = CMP_W'(didx_r) + CMP_W'(1);
  assign last_c    = (d_plus >= cnt_eff);
  assign d_zero    = (didx_r == '0);
  assign first_eff = first_r | (d_zero & in_tuser);

  // color step
  logic [7:0] ad_r, ad_g, ad_b;
  logic [sgmpca_pkg::CSUM_W-1:0] csum_c;
  assign ad_r   = (in_red   > color_r[23:16]) ? in_red   - color_r[23:16]
                                              : color_r[23:16] - in_red;
  assign ad_g   = (in_green > color_r[15:8])  ? in_green - color_r[15:8]
                                              : color_r[15:8] - in_green;
  assign ad_b   = (in_blue  > color_r[7:0])   ? in_blue  - color_r[7:0]
                                              : color_r[7:0] - in_blue;
  assign csum_c = sgmpca_pkg::CSUM_W'(ad_r) + sgmpca_pkg::CSUM_W'(ad_g)
                + sgmpca_pkg::CSUM_W'(ad_b);

  // divider step
  logic [sgmpca_pkg::DEN_W:0]   rem_sh;
  logic                         q_bit;
  assign rem_sh = {rem_r, num_r[sgmpca_pkg::NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  // adaptive penalty clamp
  logic [sgmpca_pkg::NUM_W-1:0] p1_lo, p2_hi, v_lo, v_cl;
  assign p1_lo = sgmpca_pkg::NUM_W'(p1_r) + sgmpca_pkg::NUM_W'(1);
  assign p2_hi = sgmpca_pkg::NUM_W'(p2_r);
  assign v_lo  = (num_r < p1_lo) ? p1_lo : num_r;
  assign v_cl  = (v_lo > p2_hi) ? p2_hi : v_lo;

  // minimum search
  logic [CW-1:0] w_lo, w_mid, w_hi;
  logic [SW-1:0] lo_p, hi_p, pm_p, b0, b1, b2, best_c;
  assign w_lo   = win_mid_r;
  assign w_mid  = (d_r == '0) ? rd_b_r : win_hi_r;
  assign w_hi   = rd_a_r;
  assign lo_p   = SW'(w_lo) + SW'(p1_r);
  assign hi_p   = SW'(w_hi) + SW'(p1_r);
  assign pm_p   = SW'(pmin_r) + SW'(ap2_r);
  assign b0     = SW'(w_mid);
  assign b1     = ((d_r != '0) && (lo_p < b0)) ? lo_p : b0;
  assign b2     = (!last_r && (hi_p < b1)) ? hi_p : b1;
  assign best_c = (pm_p < b2) ? pm_p : b2;

  // difference add
  logic [SW-1:0] pmin_x, diff_c;
  assign pmin_x = SW'(pmin_r);
  assign diff_c = (best_r > pmin_x) ? best_r - pmin_x : '0;

  // saturation and increment
  logic [TW-1:0] c_x, lr_c, inc_c;
  logic [CW-1:0] lr_w, rmin_c;
  assign c_x    = TW'(c_r);
  always_comb begin
    if (first_r) begin
      lr_c  = (c_x < COST_MAX_T) ? c_x : COST_MAX_T;
      inc_c = '0;
    end else begin
      lr_c  = (total_r > COST_MAX_T) ? COST_MAX_T : total_r;
      inc_c = (lr_c > c_x) ? lr_c - c_x : '0;
    end
  end
  assign lr_w   = CW'(lr_c);
  assign rmin_c = (lr_w < rmin_r) ? lr_w : rmin_r;

  logic [IDX_W-1:0] rd_idx_a;
  assign rd_idx_a = didx_r + IDX_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgmpca_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (d_zero && !first_eff) ? sgmpca_pkg::ST_DINIT : sgmpca_pkg::ST_MIN;
        end
      end
      sgmpca_pkg::ST_DINIT: state_nxt = sgmpca_pkg::ST_DIV;
      sgmpca_pkg::ST_DIV: begin
        if (dcnt_r == sgmpca_pkg::DIV_LAST) state_nxt = sgmpca_pkg::ST_P2A;
      end
      sgmpca_pkg::ST_P2A: state_nxt = sgmpca_pkg::ST_MIN;
      sgmpca_pkg::ST_MIN: state_nxt = sgmpca_pkg::ST_SUM;
      sgmpca_pkg::ST_SUM: state_nxt = sgmpca_pkg::ST_OUT;
      sgmpca_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = sgmpca_pkg::ST_IDLE;
      end
      default: state_nxt = sgmpca_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == sgmpca_pkg::ST_IDLE);
    accept    = in_tready && in_tvalid;
    rd_en     = accept;
    commit    = (state_r == sgmpca_pkg::ST_OUT) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sgmpca_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r     <= sgmpca_pkg::P1_RESET;
      p2_r     <= sgmpca_pkg::P2_RESET;
      dcount_r <= sgmpca_pkg::DCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgmpca_pkg::CFG_P1:     p1_r     <= cfg_wdata;
        sgmpca_pkg::CFG_P2:     p2_r     <= cfg_wdata;
        sgmpca_pkg::CFG_DCOUNT: dcount_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // path control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r  <= 1'b0;
      pmin_r  <= '0;
      rmin_r  <= COST_MAX;
      didx_r  <= '0;
      color_r <= '0;
      ap2_r   <= '0;
      first_r <= 1'b1;
    end else begin
      if (accept && d_zero) begin
        first_r <= first_eff;
        color_r <= {in_red, in_green, in_blue};
      end
      if (state_r == sgmpca_pkg::ST_P2A) ap2_r <= v_cl[15:0];
      if (commit) begin
        if (last_r) begin
          pmin_r  <= rmin_c;
          rmin_r  <= COST_MAX;
          bank_r  <= ~bank_r;
          didx_r  <= '0;
          first_r <= 1'b0;
        end else begin
          rmin_r <= rmin_c;
          didx_r <= d_r + IDX_W'(1);
        end
      end
    end
  end

  // per-word datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      d_r    <= didx_r;
      last_r <= last_c;
      c_r    <= in_cost;
      if (d_zero) csum_r <= csum_c;
    end
    if (state_r == sgmpca_pkg::ST_MIN) begin
      win_mid_r <= w_mid;
      win_hi_r  <= w_hi;
      best_r    <= best_c;
    end
    if (state_r == sgmpca_pkg::ST_SUM) total_r <= c_x + TW'(diff_c);
  end

  // bit-serial divider
  always_ff @(posedge clk) begin
    if (state_r == sgmpca_pkg::ST_DINIT) begin
      den_r  <= sgmpca_pkg::DEN_W'({csum_r, 3'b000}) + sgmpca_pkg::DEN_W'({csum_r, 1'b0})
              + sgmpca_pkg::DEN_W'(3);
      num_r  <= sgmpca_pkg::NUM_W'({p2_r, 5'b00000}) - sgmpca_pkg::NUM_W'({p2_r, 1'b0});
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (state_r == sgmpca_pkg::ST_DIV) begin
      rem_r  <= q_bit ? sgmpca_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                      : sgmpca_pkg::DEN_W'(rem_sh);
      num_r  <= {num_r[sgmpca_pkg::NUM_W-2:0], q_bit};
      dcnt_r <= dcnt_r + sgmpca_pkg::DIV_CNT_W'(1);
    end
  end

  // path cost memory: current bank written, previous bank read
  always_ff @(posedge clk) begin
    if (commit) mem[{bank_r, d_r}] <= lr_w;
    if (rd_en) begin
      rd_a_r <= mem[{~bank_r, rd_idx_a}];
      if (d_zero) rd_b_r <= mem[{~bank_r, IDX_W'(0)}];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {inc_c[15:0], lr_c[15:0]};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/sgmpca_checker.sv =====
// ----------------------------------------------------------------------------
// sgmpca_checker
// Port-level assertions for the SGM path cost aggregation block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgmpca_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sgmpca_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                              out_tlast
);

  // reset empties the output register
  `SGM_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid)

  // one word in flight: ready drops right after an accept
  `SGM_ASSERT(a_one_in_flight, in_tvalid && in_tready |=> !in_tready)

  // a stalled result word holds
  `SGM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind sgm_path_cost_aggregation sgmpca_checker u_sgmpca_checker (.*);
